// ----- hdl/cbq_pkg.sv -----
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types and codes for the cascaded biquad filter: item modes,
// coefficient and delay slot codes, and the control structs passed between
// the top level and the section cells.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int MODE_W    = 2;
  localparam int SECTION_W = 4;
  localparam int SLOT_W    = 3;
  localparam int REG_W     = 5;

  // Item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_FILTER   = 2'd0,
    MODE_COEF_WR  = 2'd1,
    MODE_DELAY_WR = 2'd2,
    MODE_DELAY_RD = 2'd3
  } mode_t;

  // Coefficient slots
  localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

  // Delay slots
  localparam logic [SLOT_W-1:0] SLOT_D0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_D1 = 3'd1;

  // Store access broadcast to every cell
  typedef struct packed {
    logic                 coef_we;
    logic                 delay_we;
    logic [SECTION_W-1:0] section;
    logic [SLOT_W-1:0]    slot;
  } access_t;

  // Per-cell status back to the sequencer
  typedef struct packed {
    logic y_valid;
    logic done;
    logic sat;
  } cell_ctl_t;

endpackage

// ----- hdl/cbq_cell.sv -----
// ----------------------------------------------------------------------------
// cbq_cell
// One biquad section in transposed direct form II. Holds its own five
// coefficients and two delay values, takes a sample from the previous cell
// and hands the rounded, saturated section output to the next cell.
// ----------------------------------------------------------------------------
module cbq_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEFF_WIDTH  = 18,
  parameter int DELAY_WIDTH  = 40,
  parameter int CELL_IDX     = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  cbq_pkg::access_t               access,
  input  logic signed [COEFF_WIDTH-1:0]  coeff_value,
  input  logic signed [DELAY_WIDTH-1:0]  delay_value,
  output logic signed [DELAY_WIDTH-1:0]  rd_value,
  input  logic                           x_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  output logic signed [SAMPLE_WIDTH-1:0] y,
  output cbq_pkg::cell_ctl_t             ctl
);

  localparam int PW    = SAMPLE_WIDTH + COEFF_WIDTH;
  localparam int MW    = (PW > DELAY_WIDTH) ? PW : DELAY_WIDTH;
  localparam int AW    = MW + 1;
  localparam int RW    = MW + 2;
  localparam int EW    = MW + 2;
  localparam int CFRAC = COEFF_WIDTH - 4;

  localparam logic signed [RW-1:0] RND =
    {{(RW-CFRAC){1'b0}}, 1'b1, {(CFRAC-1){1'b0}}};
  localparam logic signed [RW-1:0] Y_MAX =
    {{(RW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [RW-1:0] Y_MIN =
    {{(RW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [EW-1:0] D_MAX =
    {{(EW-DELAY_WIDTH+1){1'b0}}, {(DELAY_WIDTH-1){1'b1}}};
  localparam logic signed [EW-1:0] D_MIN =
    {{(EW-DELAY_WIDTH+1){1'b1}}, {(DELAY_WIDTH-1){1'b0}}};

  logic signed [COEFF_WIDTH-1:0] b0, b1, b2, a1, a2;
  logic signed [DELAY_WIDTH-1:0] d0, d1;
  logic signed [PW-1:0]          p0, p1, p2, q1, q2;
  logic                          v1, v2, v3;
  logic                          ysat;

  logic                          match;
  logic signed [AW-1:0]          acc;
  logic signed [RW-1:0]          ys;
  logic signed [SAMPLE_WIDTH-1:0] y_next;
  logic                          y_sat;
  logic signed [EW-1:0]          d0_sum, d1_sum;
  logic signed [DELAY_WIDTH-1:0] d0_next, d1_next;
  logic                          d_sat;

  assign match = (32'(access.section) == CELL_IDX);

  // Round half up and saturate the section output
  always_comb begin
    acc = AW'(p0) + AW'(d0);
    ys  = (RW'(acc) + RND) >>> CFRAC;
    y_sat = (ys > Y_MAX) || (ys < Y_MIN);
    if (ys > Y_MAX) begin
      y_next = Y_MAX[SAMPLE_WIDTH-1:0];
    end else if (ys < Y_MIN) begin
      y_next = Y_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_next = ys[SAMPLE_WIDTH-1:0];
    end
  end

  // Form and saturate the new delay values
  always_comb begin
    d0_sum = EW'(d1) + EW'(p1) - EW'(q1);
    d1_sum = EW'(p2) - EW'(q2);
    d_sat  = 1'b0;
    if (d0_sum > D_MAX) begin
      d0_next = D_MAX[DELAY_WIDTH-1:0];
      d_sat   = 1'b1;
    end else if (d0_sum < D_MIN) begin
      d0_next = D_MIN[DELAY_WIDTH-1:0];
      d_sat   = 1'b1;
    end else begin
      d0_next = d0_sum[DELAY_WIDTH-1:0];
    end
    if (d1_sum > D_MAX) begin
      d1_next = D_MAX[DELAY_WIDTH-1:0];
      d_sat   = 1'b1;
    end else if (d1_sum < D_MIN) begin
      d1_next = D_MIN[DELAY_WIDTH-1:0];
      d_sat   = 1'b1;
    end else begin
      d1_next = d1_sum[DELAY_WIDTH-1:0];
    end
  end

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= x_valid & en;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Feed-forward products, section output, feedback products
  always_ff @(posedge clk) begin
    if (x_valid & en) begin
      p0 <= PW'(b0) * PW'(x);
      p1 <= PW'(b1) * PW'(x);
      p2 <= PW'(b2) * PW'(x);
    end
    if (v1) begin
      y    <= y_next;
      ysat <= y_sat;
    end
    if (v2) begin
      q1 <= PW'(a1) * PW'(y);
      q2 <= PW'(a2) * PW'(y);
    end
  end

  // Load coefficients
  always_ff @(posedge clk) begin
    if (access.coef_we & match) begin
      case (access.slot)
        cbq_pkg::SLOT_B0: b0 <= coeff_value;
        cbq_pkg::SLOT_B1: b1 <= coeff_value;
        cbq_pkg::SLOT_B2: b2 <= coeff_value;
        cbq_pkg::SLOT_A1: a1 <= coeff_value;
        cbq_pkg::SLOT_A2: a2 <= coeff_value;
        default: ;
      endcase
    end
  end

  // Update or load the delay values
  always_ff @(posedge clk) begin
    if (rst) begin
      d0 <= '0;
      d1 <= '0;
    end else if (v3) begin
      d0 <= d0_next;
      d1 <= d1_next;
    end else if (access.delay_we & match) begin
      case (access.slot)
        cbq_pkg::SLOT_D0: d0 <= delay_value;
        cbq_pkg::SLOT_D1: d1 <= delay_value;
        default: ;
      endcase
    end
  end

  // Drive the readback, zero unless this cell is addressed
  always_comb begin
    rd_value = '0;
    if (match) begin
      case (access.slot)
        cbq_pkg::SLOT_D0: rd_value = d0;
        cbq_pkg::SLOT_D1: rd_value = d1;
        default: rd_value = '0;
      endcase
    end
  end

  assign ctl.y_valid = v2;
  assign ctl.done    = v3;
  assign ctl.sat     = (v2 & ysat) | (v3 & d_sat);

endmodule

// ----- hdl/cascaded_biquad_iir_filter.sv -----
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter
// Second-order-section IIR filter: a row of biquad cells, one per section,
// with a small sequencer that takes transactions, routes store accesses and
// collects the filtered sample or the delay readback.
// ----------------------------------------------------------------------------
// Operation: a filter transaction through n = min(active_sections, MAX_SECTIONS)
//   sections passes each cell in turn before out_valid rises; other
//   transactions and n = 0 bypass the chain.
// Flow: one transaction at a time; in_stall holds off a new one until the
//   result moves to the output register. Each cell multiplies, then rounds.
// Reset: rst clears all delay values, sets active_sections to 1 and empties
//   the pipeline; coefficients are undefined until written.
module cascaded_biquad_iir_filter #(
  parameter int MAX_SECTIONS = 16,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEFF_WIDTH  = 18,
  parameter int DELAY_WIDTH  = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [cbq_pkg::REG_W-1:0]        cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cbq_pkg::MODE_W-1:0]       mode,
  input  logic [cbq_pkg::SECTION_W-1:0]    section,
  input  logic [cbq_pkg::SLOT_W-1:0]       slot,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
  input  logic signed [COEFF_WIDTH-1:0]    coeff_value,
  input  logic signed [DELAY_WIDTH-1:0]    delay_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out,
  output logic signed [DELAY_WIDTH-1:0]    delay_readback,
  output logic                             saturated
);

  logic [cbq_pkg::REG_W-1:0]       active_sections;
  logic                            busy;
  logic                            fin;
  logic                            start;
  logic signed [SAMPLE_WIDTH-1:0]  x_reg;
  logic signed [SAMPLE_WIDTH-1:0]  y_hold;
  logic signed [DELAY_WIDTH-1:0]   rb_hold;
  logic                            sat_hold;

  logic                            accept;
  logic                            xfer;
  cbq_pkg::access_t                access;
  cbq_pkg::mode_t                  mode_sel;

  logic [MAX_SECTIONS-1:0]         en;
  logic [MAX_SECTIONS-1:0]         last;
  logic [MAX_SECTIONS-1:0]         yv_vec;
  logic [MAX_SECTIONS-1:0]         done_vec;
  logic [MAX_SECTIONS-1:0]         sat_vec;
  cbq_pkg::cell_ctl_t              ctl   [MAX_SECTIONS];
  logic signed [SAMPLE_WIDTH-1:0]  y_arr [MAX_SECTIONS];
  logic signed [DELAY_WIDTH-1:0]   rd_arr[MAX_SECTIONS];

  logic signed [DELAY_WIDTH-1:0]   rd_any;
  logic signed [SAMPLE_WIDTH-1:0]  y_last;
  logic                            y_last_valid;
  logic                            last_done;

  assign in_stall = busy;
  assign accept   = in_valid & ~busy;
  assign xfer     = fin & (~out_valid | ~out_stall);
  assign mode_sel = cbq_pkg::mode_t'(mode);

  // Broadcast store accesses to the cells
  always_comb begin
    access.coef_we  = accept & (mode_sel == cbq_pkg::MODE_COEF_WR);
    access.delay_we = accept & (mode_sel == cbq_pkg::MODE_DELAY_WR);
    access.section  = section;
    access.slot     = slot;
  end

  // Chain of section cells
  for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
    logic                           cx_valid;
    logic signed [SAMPLE_WIDTH-1:0] cx;

    if (i == 0) begin : g_head
      assign cx_valid = start;
      assign cx       = x_reg;
    end else begin : g_link
      assign cx_valid = ctl[i-1].y_valid;
      assign cx       = y_arr[i-1];
    end

    if (i == MAX_SECTIONS - 1) begin : g_tail
      assign last[i] = (32'(active_sections) >= MAX_SECTIONS);
    end else begin : g_mid
      assign last[i] = (32'(active_sections) == i + 1);
    end

    assign en[i]       = (32'(active_sections) > i);
    assign yv_vec[i]   = ctl[i].y_valid;
    assign done_vec[i] = ctl[i].done;
    assign sat_vec[i]  = ctl[i].sat;

    cbq_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEFF_WIDTH  (COEFF_WIDTH),
      .DELAY_WIDTH  (DELAY_WIDTH),
      .CELL_IDX     (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          (en[i]),
      .access      (access),
      .coeff_value (coeff_value),
      .delay_value (delay_value),
      .rd_value    (rd_arr[i]),
      .x_valid     (cx_valid),
      .x           (cx),
      .y           (y_arr[i]),
      .ctl         (ctl[i])
    );
  end

  // Gather readback and the output of the last active section
  always_comb begin
    rd_any = '0;
    y_last = '0;
    for (int i = 0; i < MAX_SECTIONS; i++) begin
      rd_any = rd_any | rd_arr[i];
      y_last = y_last | (y_arr[i] & {SAMPLE_WIDTH{yv_vec[i] & last[i]}});
    end
    y_last_valid = |(yv_vec & last);
    last_done    = |(done_vec & last);
  end

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_sections <= cbq_pkg::REG_W'(1);
    end else if (cfg_wr_en) begin
      active_sections <= cfg_wr_data;
    end
  end

  // Sequence one transaction at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      fin   <= 1'b0;
      start <= 1'b0;
    end else begin
      start <= 1'b0;
      if (accept) begin
        busy <= 1'b1;
        if (mode_sel == cbq_pkg::MODE_FILTER && active_sections != '0) begin
          start <= 1'b1;
        end else begin
          fin <= 1'b1;
        end
      end else if (last_done) begin
        fin <= 1'b1;
      end else if (xfer) begin
        fin  <= 1'b0;
        busy <= 1'b0;
      end
    end
  end

  // Collect the result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg    <= sample_in;
      sat_hold <= 1'b0;
      case (mode_sel)
        cbq_pkg::MODE_FILTER: begin
          y_hold  <= sample_in;
          rb_hold <= '0;
        end
        cbq_pkg::MODE_DELAY_RD: begin
          y_hold  <= '0;
          rb_hold <= rd_any;
        end
        default: begin
          y_hold  <= '0;
          rb_hold <= '0;
        end
      endcase
    end else begin
      if (|sat_vec) begin
        sat_hold <= 1'b1;
      end
      if (y_last_valid) begin
        y_hold <= y_last;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (xfer) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      sample_out     <= y_hold;
      delay_readback <= rb_hold;
      saturated      <= sat_hold;
    end
  end

`ifndef SYNTHESIS
  a_idle_cells: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (yv_vec == '0) && (done_vec == '0))
    else $error("section cell active with no transaction in flight");

  a_fin_busy: assert property (@(posedge clk) disable iff (rst)
    fin |-> busy)
    else $error("result finished without a transaction in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> busy)
    else $error("accepted transaction did not mark the block busy");

  a_start_pulse: assert property (@(posedge clk) disable iff (rst)
    start |=> !start)
    else $error("chain start held for more than one cycle");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    last_done |-> !fin)
    else $error("last section finished while a result was already held");
`endif

endmodule
